FILE: src/ball_pkg.sv
// ----------------------------------------------------------------------------
// ball_pkg
// Shared constants for the bounded array list engine: request kinds,
// result status codes and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ball_pkg;

   localparam int DATA_W   = 32;
   localparam int KIND_W   = 4;
   localparam int STATUS_W = 2;
   localparam int OUT_W    = 5;

   localparam logic [KIND_W-1:0] KIND_CLEAR     = 4'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND    = 4'd1;
   localparam logic [KIND_W-1:0] KIND_DEL_FIRST = 4'd2;
   localparam logic [KIND_W-1:0] KIND_DEL_ALL   = 4'd3;
   localparam logic [KIND_W-1:0] KIND_REPLACE   = 4'd4;
   localparam logic [KIND_W-1:0] KIND_FIND      = 4'd5;
   localparam logic [KIND_W-1:0] KIND_COUNT     = 4'd6;
   localparam logic [KIND_W-1:0] KIND_MAX       = 4'd7;
   localparam logic [KIND_W-1:0] KIND_MIN       = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

   typedef logic signed [DATA_W-1:0] data_type;

endpackage

`default_nettype wire

FILE: src/ball_mem.sv
// ----------------------------------------------------------------------------
// ball_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ball_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic                  clock,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output      ball_pkg::data_type    rd_data,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire ball_pkg::data_type    wr_data
);
   import ball_pkg::*;

   data_type mem [DEPTH];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: src/bounded_array_list_engine_core.sv
// ----------------------------------------------------------------------------
// bounded_array_list_engine_core
// Packed list of signed 32-bit entries with a fill count, held in one
// synchronous memory and worked on by a read-modify-write scan sequencer.
//
// Usage:
//  - req_ channel carries one request item (kind, value, new_value); the
//    block holds req_stall high while it works on an item.
//  - rsp_ channel returns exactly one result item per request, from an
//    output register; the next request is taken while a result waits.
//  - Match, max and min items run one pass over the stored entries, one
//    memory read per cycle. Clear, append, unknown kinds and any item on
//    an empty list skip the pass.
//  - Deletes compact the list during the same pass, writing each kept
//    entry to its new place behind the read pointer.
//  - Reset empties the list at once; entry contents are not cleared.
//  - When rsp_stall holds a result, a finished item waits in the final
//    step until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine_core #(
   parameter int CAPACITY = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire logic [3:0]                req_kind,
   input  wire logic signed [31:0]        req_value,
   input  wire logic signed [31:0]        req_new_value,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      logic [1:0]                rsp_status,
   output      logic [4:0]                rsp_position,
   output      logic [4:0]                rsp_match_count,
   output      logic signed [31:0]        rsp_extreme,
   output      logic [4:0]                rsp_fill,
   output      logic                      rsp_is_empty,
   output      logic                      rsp_is_full
);
   import ball_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   data_type             val_ff, val_in;
   data_type             nval_ff, nval_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [CW-1:0]        lim_ff, lim_in;
   logic [CW-1:0]        rd_ff, rd_in;
   logic                 pv_ff, pv_in;
   logic [AW-1:0]        pi_ff, pi_in;
   logic [CW-1:0]        hits_ff, hits_in;
   logic [CW-1:0]        first_ff, first_in;
   logic [CW-1:0]        w_ff, w_in;
   data_type             ext_ff, ext_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [OUT_W-1:0]     pos_ff, pos_in;
   logic [OUT_W-1:0]     mcnt_ff, mcnt_in;
   data_type             oext_ff, oext_in;
   logic [OUT_W-1:0]     fill_ff, fill_in;
   logic                 empty_ff, empty_in;
   logic                 full_ff, full_in;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   data_type             rd_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   data_type             wr_data;

   logic                 req_fire;
   logic                 out_free;
   logic                 match;
   logic                 scan_kind;
   logic                 hit;

   ball_mem #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign match     = pv_ff && (rd_data == val_ff);
   assign scan_kind = (req_kind >= KIND_DEL_FIRST) && (req_kind <= KIND_MIN);
   assign hit       = (hits_ff != '0);

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      val_in       = val_ff;
      nval_in      = nval_ff;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      rd_in        = rd_ff;
      pv_in        = 1'b0;
      pi_in        = pi_ff;
      hits_in      = hits_ff;
      first_in     = first_ff;
      w_in         = w_ff;
      ext_in       = ext_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      pos_in       = pos_ff;
      mcnt_in      = mcnt_ff;
      oext_in      = oext_ff;
      fill_in      = fill_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;
      rd_en        = 1'b0;
      rd_addr      = rd_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = w_ff[AW-1:0];
      wr_data      = rd_data;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in  = req_kind;
               val_in   = req_value;
               nval_in  = req_new_value;
               lim_in   = scan_kind ? cnt_ff : '0;
               rd_in    = '0;
               hits_in  = '0;
               first_in = '0;
               w_in     = '0;
               ext_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (rd_ff < lim_ff) begin
               rd_en = 1'b1;
               pv_in = 1'b1;
               pi_in = rd_ff[AW-1:0];
               rd_in = rd_ff + CW'(1);
            end else if (!pv_ff) begin
               state_in = S_FIN;
            end
            if (pv_ff) begin
               if (match) begin
                  hits_in = hits_ff + CW'(1);
                  if (!hit) begin
                     first_in = CW'(pi_ff) + CW'(1);
                  end
               end
               if (pi_ff == '0) begin
                  ext_in = rd_data;
               end else if (kind_ff == KIND_MAX) begin
                  if (ext_ff < rd_data) begin
                     ext_in = rd_data;
                  end
               end else if (rd_data < ext_ff) begin
                  ext_in = rd_data;
               end
               if (kind_ff == KIND_DEL_ALL && !match) begin
                  wr_en   = 1'b1;
                  wr_addr = w_ff[AW-1:0];
                  w_in    = w_ff + CW'(1);
               end
               if (kind_ff == KIND_DEL_FIRST && hit) begin
                  wr_en   = 1'b1;
                  wr_addr = pi_ff - AW'(1);
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               status_in = ST_OK;
               pos_in    = '0;
               mcnt_in   = '0;
               oext_in   = '0;
               cnt_in    = cnt_ff;
               case (kind_ff)
                  KIND_CLEAR: begin
                     cnt_in = '0;
                  end
                  KIND_APPEND: begin
                     if (cnt_ff == CW'(CAPACITY)) begin
                        status_in = ST_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = cnt_ff[AW-1:0];
                        wr_data = val_ff;
                        cnt_in  = cnt_ff + CW'(1);
                     end
                  end
                  KIND_DEL_FIRST, KIND_DEL_ALL, KIND_REPLACE, KIND_FIND, KIND_COUNT: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else if (!hit) begin
                        status_in = ST_NOTFOUND;
                     end else begin
                        pos_in = OUT_W'(first_ff);
                        case (kind_ff)
                           KIND_DEL_FIRST: begin
                              cnt_in  = cnt_ff - CW'(1);
                              mcnt_in = OUT_W'(1);
                           end
                           KIND_DEL_ALL: begin
                              cnt_in  = w_ff;
                              mcnt_in = OUT_W'(hits_ff);
                           end
                           KIND_REPLACE: begin
                              wr_en   = 1'b1;
                              wr_addr = AW'(first_ff - CW'(1));
                              wr_data = nval_ff;
                              mcnt_in = OUT_W'(1);
                           end
                           KIND_COUNT: begin
                              mcnt_in = OUT_W'(hits_ff);
                           end
                           default: begin
                           end
                        endcase
                     end
                  end
                  KIND_MAX, KIND_MIN: begin
                     if (cnt_ff == '0) begin
                        status_in = ST_EMPTY;
                     end else begin
                        oext_in = ext_ff;
                     end
                  end
                  default: begin
                  end
               endcase
               fill_in      = OUT_W'(cnt_in);
               empty_in     = (cnt_in == '0);
               full_in      = (cnt_in == CW'(CAPACITY));
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      val_ff    <= val_in;
      nval_ff   <= nval_in;
      lim_ff    <= lim_in;
      rd_ff     <= rd_in;
      pi_ff     <= pi_in;
      hits_ff   <= hits_in;
      first_ff  <= first_in;
      w_ff      <= w_in;
      ext_ff    <= ext_in;
      status_ff <= status_in;
      pos_ff    <= pos_in;
      mcnt_ff   <= mcnt_in;
      oext_ff   <= oext_in;
      fill_ff   <= fill_in;
      empty_ff  <= empty_in;
      full_ff   <= full_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_position    = pos_ff;
   assign rsp_match_count = mcnt_ff;
   assign rsp_extreme     = oext_ff;
   assign rsp_fill        = fill_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;

endmodule

`default_nettype wire
